[src/brwf_pkg.sv]
// ----------------------------------------------------------------------------
// brwf_pkg
// Shared types and codes for the bilinear resampler with fill handling.
// ----------------------------------------------------------------------------
`default_nettype none

package brwf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_VALUE     = 3'd0,
    CFG_FILL_THRESHOLD = 3'd1,
    CFG_IMAGE_LINES    = 3'd2,
    CFG_IMAGE_SAMPLES  = 3'd3
  } cfg_reg_t;

  // Item kinds carried in tuser
  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_RESAMPLE = 1'b1;

  // Fixed field widths
  localparam int PIX_W    = 32;
  localparam int COORD_W  = 28;
  localparam int LOAD_W   = 9;
  localparam int SIZE_W   = 10;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;

  // Result that skips the interpolation (outside raster or fill neighbor)
  typedef struct packed {
    logic              bypass;
    logic              is_fill;
    logic [PIX_W-1:0]  value;
  } bypass_t;

endpackage

`default_nettype wire

[src/bilinear_resample_with_fill_top.sv]
// ----------------------------------------------------------------------------
// bilinear_resample_with_fill_top
// Banked raster store with a pipelined bilinear resampler and fill handling.
// ----------------------------------------------------------------------------
// The block takes one word per cycle, load or resample, and keeps taking words
// while results wait downstream until its seven pipeline stages are full. A
// load word writes one pixel into one of four raster banks, split by the
// parity of line and sample, so that a resample word reads its four
// neighbors in the same cycle, one from each bank. A resample result passes
// through the bank read, then neighbor selection, two horizontal multiplies,
// the horizontal sums, the vertical difference, the vertical multiply and the
// final sum with saturation into the output register. Loads give no result. A
// pixel must be loaded before any resample word that reads it. The user must
// write configuration only while no word is in flight; the block itself does
// not enforce this.
`default_nettype none

module bilinear_resample_with_fill_top #(
  parameter int MAX_LINES   = 512,
  parameter int MAX_SAMPLES = 512,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [brwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata: load_line[8:0], load_sample[17:9], pixel_value[49:18],
  //           coord_line[77:50], coord_sample[105:78], zero pad[111:106]
  input  wire logic [brwf_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[0]
  input  wire logic [0:0]                      in_tuser,
  // output stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: output_value[31:0]
  output logic [brwf_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: is_fill[0]
  output logic [0:0]                           out_tuser
);

  // Index widths: at least two bits so the bank row part is never empty
  localparam int LW     = (MAX_LINES   > 2) ? $clog2(MAX_LINES)   : 2;
  localparam int SW     = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 2;
  localparam int AW     = (LW - 1) + (SW - 1);
  localparam int DEPTH  = 1 << AW;
  localparam int IDX_W  = 13;
  localparam int F      = FRAC_BITS;
  localparam int PW0    = 33 + F + 1;
  localparam int PW2    = 34 + F + 1;
  localparam int PIX_W  = brwf_pkg::PIX_W;
  localparam int CW     = brwf_pkg::COORD_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] fill_value_r;
  logic [31:0] fill_threshold_r;
  logic [brwf_pkg::SIZE_W-1:0] image_lines_r;
  logic [brwf_pkg::SIZE_W-1:0] image_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_value_r     <= '0;
      fill_threshold_r <= '0;
      image_lines_r    <= 10'd512;
      image_samples_r  <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        brwf_pkg::CFG_FILL_VALUE:     fill_value_r     <= cfg_wdata;
        brwf_pkg::CFG_FILL_THRESHOLD: fill_threshold_r <= cfg_wdata;
        brwf_pkg::CFG_IMAGE_LINES:    image_lines_r    <= cfg_wdata[brwf_pkg::SIZE_W-1:0];
        brwf_pkg::CFG_IMAGE_SAMPLES:  image_samples_r  <= cfg_wdata[brwf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster size clamped to the store
  logic [IDX_W-1:0] n_lines;
  logic [IDX_W-1:0] n_samples;
  assign n_lines   = ({3'b0, image_lines_r} > IDX_W'(MAX_LINES)) ?
                     IDX_W'(MAX_LINES) : {3'b0, image_lines_r};
  assign n_samples = ({3'b0, image_samples_r} > IDX_W'(MAX_SAMPLES)) ?
                     IDX_W'(MAX_SAMPLES) : {3'b0, image_samples_r};

  // --------------------------------------------------------------------------
  // Stage advance chain: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

  assign ld7 = !out_valid_r || out_tready;
  assign ld6 = !s6_v_r || ld7;
  assign ld5 = !s5_v_r || ld6;
  assign ld4 = !s4_v_r || ld5;
  assign ld3 = !s3_v_r || ld4;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;

  assign in_tready = ld1;

  logic accept;
  assign accept = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Input word decode
  // --------------------------------------------------------------------------
  logic                    mode;
  logic [brwf_pkg::LOAD_W-1:0] load_line, load_sample;
  logic [PIX_W-1:0]        pixel_value;
  logic [CW-1:0]           coord_line, coord_sample;

  assign mode         = in_tuser[0];
  assign load_line    = in_tdata[8:0];
  assign load_sample  = in_tdata[17:9];
  assign pixel_value  = in_tdata[49:18];
  assign coord_line   = in_tdata[77:50];
  assign coord_sample = in_tdata[105:78];

  // Load address and bank
  logic [IDX_W-1:0] ld_l13, ld_s13;
  logic [LW-1:0]    ld_l;
  logic [SW-1:0]    ld_s;
  logic             wr_en;
  logic [1:0]       wr_bank;
  logic [AW-1:0]    wr_addr;

  assign ld_l13  = {4'b0, load_line};
  assign ld_s13  = {4'b0, load_sample};
  assign ld_l    = ld_l13[LW-1:0];
  assign ld_s    = ld_s13[SW-1:0];
  assign wr_en   = accept && (mode == brwf_pkg::MODE_LOAD) &&
                   (ld_l13 < IDX_W'(MAX_LINES)) && (ld_s13 < IDX_W'(MAX_SAMPLES));
  assign wr_bank = {ld_l[0], ld_s[0]};
  assign wr_addr = {ld_l[LW-1:1], ld_s[SW-1:1]};

  // Integer part of the coordinates and range check
  logic signed [31:0] cl_ext, cs_ext;
  logic        [31:0] il_u, is_u;
  logic               in_range;
  logic [LW-1:0]      c_l;
  logic [SW-1:0]      c_s;

  assign cl_ext   = {{(32-CW){coord_line[CW-1]}}, coord_line};
  assign cs_ext   = {{(32-CW){coord_sample[CW-1]}}, coord_sample};
  assign il_u     = 32'(cl_ext >>> F);
  assign is_u     = 32'(cs_ext >>> F);
  assign in_range = !coord_line[CW-1] && !coord_sample[CW-1] &&
                    ((il_u + 32'd1) < {19'd0, n_lines}) &&
                    ((is_u + 32'd1) < {19'd0, n_samples});
  assign c_l      = il_u[LW-1:0];
  assign c_s      = is_u[SW-1:0];

  // Bank rows: even-parity banks hold index+1 when the base index is odd
  logic [LW-2:0] row_l_even, row_l_odd;
  logic [SW-2:0] row_s_even, row_s_odd;
  logic [AW-1:0] rd_addr [4];

  assign row_l_odd  = c_l[LW-1:1];
  assign row_l_even = c_l[LW-1:1] + (LW-1)'(c_l[0]);
  assign row_s_odd  = c_s[SW-1:1];
  assign row_s_even = c_s[SW-1:1] + (SW-1)'(c_s[0]);

  always_comb begin
    rd_addr[0] = {row_l_even, row_s_even};
    rd_addr[1] = {row_l_even, row_s_odd};
    rd_addr[2] = {row_l_odd,  row_s_even};
    rd_addr[3] = {row_l_odd,  row_s_odd};
  end

  // --------------------------------------------------------------------------
  // Raster banks; a write lands before any later word's read; while not stalled, one word a cycle
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_rd_r [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= pixel_value;
      end
      if (ld1) begin
        s1_rd_r[b] <= mem[rd_addr[b]];
      end
    end
  end

  // Stage 1 side data
  logic          s1_oob_r, s1_l0_r, s1_s0_r;
  logic [F-1:0]  s1_fl_r, s1_fs_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_oob_r <= !in_range;
      s1_l0_r  <= c_l[0];
      s1_s0_r  <= c_s[0];
      s1_fl_r  <= coord_line[F-1:0];
      s1_fs_r  <= coord_sample[F-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: neighbor order, fill check, horizontal differences
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [3:0]       below;
  brwf_pkg::bypass_t s2_ctl_nxt;

  assign p00 = s1_rd_r[{s1_l0_r,  s1_s0_r}];
  assign p01 = s1_rd_r[{s1_l0_r, !s1_s0_r}];
  assign p10 = s1_rd_r[{!s1_l0_r,  s1_s0_r}];
  assign p11 = s1_rd_r[{!s1_l0_r, !s1_s0_r}];

  assign below[0] = $signed(p00) < $signed(fill_threshold_r);
  assign below[1] = $signed(p01) < $signed(fill_threshold_r);
  assign below[2] = $signed(p10) < $signed(fill_threshold_r);
  assign below[3] = $signed(p11) < $signed(fill_threshold_r);

  always_comb begin
    s2_ctl_nxt.bypass  = 1'b1;
    s2_ctl_nxt.is_fill = 1'b0;
    s2_ctl_nxt.value   = p00;
    if (s1_oob_r) begin
      s2_ctl_nxt.is_fill = 1'b1;
      s2_ctl_nxt.value   = fill_value_r;
    end else if (below[0]) begin
      s2_ctl_nxt.value = p00;
    end else if (below[1]) begin
      s2_ctl_nxt.value = p01;
    end else if (below[2]) begin
      s2_ctl_nxt.value = p10;
    end else if (below[3]) begin
      s2_ctl_nxt.value = p11;
    end else begin
      s2_ctl_nxt.bypass = 1'b0;
    end
  end

  brwf_pkg::bypass_t   s2_ctl_r;
  logic signed [32:0]  s2_p00_r, s2_p10_r, s2_d0_r, s2_d1_r;
  logic [F-1:0]        s2_fl_r, s2_fs_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ctl_r <= s2_ctl_nxt;
      s2_p00_r <= $signed({p00[31], p00});
      s2_p10_r <= $signed({p10[31], p10});
      s2_d0_r  <= $signed({p01[31], p01}) - $signed({p00[31], p00});
      s2_d1_r  <= $signed({p11[31], p11}) - $signed({p10[31], p10});
      s2_fl_r  <= s1_fl_r;
      s2_fs_r  <= s1_fs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: horizontal products
  // --------------------------------------------------------------------------
  logic signed [F:0]     fs_x;
  brwf_pkg::bypass_t     s3_ctl_r;
  logic signed [32:0]    s3_p00_r, s3_p10_r;
  logic signed [PW0-1:0] s3_prod0_r, s3_prod1_r;
  logic [F-1:0]          s3_fl_r;

  assign fs_x = $signed({1'b0, s2_fs_r});

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_ctl_r   <= s2_ctl_r;
      s3_p00_r   <= s2_p00_r;
      s3_p10_r   <= s2_p10_r;
      s3_prod0_r <= s2_d0_r * fs_x;
      s3_prod1_r <= s2_d1_r * fs_x;
      s3_fl_r    <= s2_fl_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: horizontal sums, products floored by arithmetic shift
  // --------------------------------------------------------------------------
  logic signed [PW0-1:0] sh0, sh1;
  brwf_pkg::bypass_t     s4_ctl_r;
  logic signed [32:0]    s4_a_r, s4_b_r;
  logic [F-1:0]          s4_fl_r;

  assign sh0 = s3_prod0_r >>> F;
  assign sh1 = s3_prod1_r >>> F;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_ctl_r <= s3_ctl_r;
      s4_a_r   <= s3_p00_r + $signed(sh0[32:0]);
      s4_b_r   <= s3_p10_r + $signed(sh1[32:0]);
      s4_fl_r  <= s3_fl_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: vertical difference
  // --------------------------------------------------------------------------
  brwf_pkg::bypass_t  s5_ctl_r;
  logic signed [32:0] s5_a_r;
  logic signed [33:0] s5_d2_r;
  logic [F-1:0]       s5_fl_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_ctl_r <= s4_ctl_r;
      s5_a_r   <= s4_a_r;
      s5_d2_r  <= $signed({s4_b_r[32], s4_b_r}) - $signed({s4_a_r[32], s4_a_r});
      s5_fl_r  <= s4_fl_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: vertical product
  // --------------------------------------------------------------------------
  logic signed [F:0]     fl_x;
  brwf_pkg::bypass_t     s6_ctl_r;
  logic signed [32:0]    s6_a_r;
  logic signed [PW2-1:0] s6_prod2_r;

  assign fl_x = $signed({1'b0, s5_fl_r});

  always_ff @(posedge clk) begin
    if (ld6) begin
      s6_ctl_r   <= s5_ctl_r;
      s6_a_r     <= s5_a_r;
      s6_prod2_r <= s5_d2_r * fl_x;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: final sum, saturation, result select into the output register
  // --------------------------------------------------------------------------
  logic signed [PW2-1:0] sh2;
  logic signed [34:0]    r_sum;
  logic [PIX_W-1:0]      r_sat;
  logic [PIX_W-1:0]      out_value_nxt;
  logic [PIX_W-1:0]      out_value_r;
  logic                  out_fill_r;

  assign sh2   = s6_prod2_r >>> F;
  assign r_sum = $signed({{2{s6_a_r[32]}}, s6_a_r}) + $signed(sh2[34:0]);

  always_comb begin
    if (r_sum > 35'sh0_7FFF_FFFF) begin
      r_sat = 32'h7FFF_FFFF;
    end else if (r_sum < -35'sh0_8000_0000) begin
      r_sat = 32'h8000_0000;
    end else begin
      r_sat = r_sum[31:0];
    end
    out_value_nxt = s6_ctl_r.bypass ? s6_ctl_r.value : r_sat;
  end

  always_ff @(posedge clk) begin
    if (ld7) begin
      out_value_r <= out_value_nxt;
      out_fill_r  <= s6_ctl_r.bypass && s6_ctl_r.is_fill;
    end
  end

  // Valid bits; loads leave the pipe at the banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) s1_v_r      <= accept && (mode == brwf_pkg::MODE_RESAMPLE);
      if (ld2) s2_v_r      <= s1_v_r;
      if (ld3) s3_v_r      <= s2_v_r;
      if (ld4) s4_v_r      <= s3_v_r;
      if (ld5) s5_v_r      <= s4_v_r;
      if (ld6) s6_v_r      <= s5_v_r;
      if (ld7) out_valid_r <= s6_v_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_fill_r;

endmodule

`default_nettype wire

[src/brwf_checker.sv]
// ----------------------------------------------------------------------------
// brwf_checker
// Port-level checks of the resampler's stream behavior, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module brwf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [brwf_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]                      out_tuser
);

  // A stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or vanished");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // With no result waiting, the pipe is not full and takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // A full, stalled pipe stays full until the output drains
  a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tready |=> !in_tready || out_tready)
    else $error("full pipe accepted input without draining");

endmodule

bind bilinear_resample_with_fill_top brwf_checker u_brwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[tb/bilinear_resample_with_fill_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_resample_with_fill_top_test
// Self-checking bench for the bilinear resampler with fill handling.
// ----------------------------------------------------------------------------
// Loads 2x2 pixel patches into the raster and resamples inside them, at the
// raster edges and outside it, under several register settings. A local copy
// of the raster and registers predicts every result word; a checker compares
// each result word against the oldest prediction. Both stream sides idle in
// random bursts, except during the last phase.
module bilinear_resample_with_fill_top_test;

  localparam int FRAC            = 16;
  localparam int LINES_MAX       = 512;
  localparam int SAMPLES_MAX     = 512;
  localparam int PIPE_DEPTH      = 7;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int CW              = brwf_pkg::COORD_W;
  localparam logic [brwf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
  localparam logic [31:0] PIX_MIN = 32'h8000_0000;
  localparam logic [31:0] PIX_MAX = 32'h7FFF_FFFF;
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

  // one input word, fields from the highest bit down
  typedef struct packed {
    logic                               mode;
    logic signed [brwf_pkg::COORD_W-1:0] coord_sample;
    logic signed [brwf_pkg::COORD_W-1:0] coord_line;
    logic [brwf_pkg::PIX_W-1:0]         pixel;
    logic [brwf_pkg::LOAD_W-1:0]        load_sample;
    logic [brwf_pkg::LOAD_W-1:0]        load_line;
  } word_t;

  typedef struct {
    logic [brwf_pkg::PIX_W-1:0] value;
    logic                       is_fill;
  } result_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [brwf_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [31:0]                     cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [brwf_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]                      in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [brwf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;

  // predictor state
  logic [brwf_pkg::PIX_W-1:0] raster_model [0:LINES_MAX*SAMPLES_MAX-1];
  bit               pix_written  [0:LINES_MAX*SAMPLES_MAX-1];
  bit               anchor_ready [0:LINES_MAX*SAMPLES_MAX-1];
  int               anchors[$];
  logic [31:0]      fill_val_r = '0;
  logic [31:0]      fill_thr_r = '0;
  logic [9:0]       lines_r    = 10'd512;
  logic [9:0]       samples_r  = 10'd512;

  result_t expected_pixels[$];
  int      mismatches = 0;
  bit      quiet      = 1'b0;
  int      stall_left = 0;

  bilinear_resample_with_fill_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int pix_addr(int l, int s);
    return l * SAMPLES_MAX + s;
  endfunction

  function automatic longint interp_step(longint a, longint b, longint f);
    // arithmetic shift of a signed value is floor division
    return a + (((b - a) * f) >>> FRAC);
  endfunction

  function automatic longint lines_used();
    return (lines_r > LINES_MAX) ? LINES_MAX : longint'(lines_r);
  endfunction

  function automatic longint samples_used();
    return (samples_r > SAMPLES_MAX) ? SAMPLES_MAX : longint'(samples_r);
  endfunction

  function automatic bit inside_raster(longint cl, longint cs);
    return !(cl < 0 || cs < 0 || (cl >>> FRAC) >= lines_used() - 1 ||
             (cs >>> FRAC) >= samples_used() - 1);
  endfunction

  // in range but neighbors not all loaded: must never be sent
  function automatic bit reads_unwritten(longint cl, longint cs);
    return inside_raster(cl, cs) &&
           !anchor_ready[pix_addr(int'(cl >>> FRAC), int'(cs >>> FRAC))];
  endfunction

  function automatic result_t resample_expect(word_t w);
    result_t res;
    longint  cl, cs, li, si, fl, fs, thr, a, b, r, mask;
    longint  p [4];
    cl   = w.coord_line;
    cs   = w.coord_sample;
    mask = (longint'(1) << FRAC) - 1;
    res.is_fill = 1'b0;
    if (!inside_raster(cl, cs)) begin
      res.value   = fill_val_r;
      res.is_fill = 1'b1;
      return res;
    end
    li   = cl >>> FRAC;
    si   = cs >>> FRAC;
    fl   = cl & mask;
    fs   = cs & mask;
    thr  = longint'($signed(fill_thr_r));
    p[0] = longint'($signed(raster_model[pix_addr(int'(li), int'(si))]));
    p[1] = longint'($signed(raster_model[pix_addr(int'(li), int'(si) + 1)]));
    p[2] = longint'($signed(raster_model[pix_addr(int'(li) + 1, int'(si))]));
    p[3] = longint'($signed(raster_model[pix_addr(int'(li) + 1, int'(si) + 1)]));
    // first neighbor below the threshold passes straight through
    for (int k = 0; k < 4; k++) begin
      if (p[k] < thr) begin
        res.value = 32'(p[k]);
        return res;
      end
    end
    a = interp_step(p[0], p[1], fs);
    b = interp_step(p[2], p[3], fs);
    r = interp_step(a, b, fl);
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    res.value = 32'(r);
    return res;
  endfunction

  // ---------------------------------------------------------------- builders
  function automatic logic [brwf_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [brwf_pkg::COORD_W-1:0] fix_q(int whole, logic [15:0] frac);
    return {whole[11:0], frac};
  endfunction

  function automatic logic [31:0] pick_size();
    logic [9:0] n;
    case ($urandom_range(0, 7))
      0:       n = 10'd512;
      1:       n = 10'd2;
      2:       n = 10'($urandom_range(0, 1));
      3:       n = 10'($urandom_range(513, 1023));
      default: n = 10'($urandom_range(2, 512));
    endcase
    // upper bits are not part of the register
    return ($urandom & 32'hFFFF_FC00) | {22'd0, n};
  endfunction

  function automatic word_t load_word(int l, int s, logic [brwf_pkg::PIX_W-1:0] v);
    word_t        w;
    logic [127:0] noise;
    noise         = {$urandom, $urandom, $urandom, $urandom};
    w             = noise[$bits(word_t)-1:0];
    w.mode        = brwf_pkg::MODE_LOAD;
    w.load_line   = l[brwf_pkg::LOAD_W-1:0];
    w.load_sample = s[brwf_pkg::LOAD_W-1:0];
    w.pixel       = v;
    return w;
  endfunction

  function automatic word_t resample_word(logic [brwf_pkg::COORD_W-1:0] cl,
                                          logic [brwf_pkg::COORD_W-1:0] cs);
    word_t        w;
    logic [127:0] noise;
    noise          = {$urandom, $urandom, $urandom, $urandom};
    w              = noise[$bits(word_t)-1:0];
    w.mode         = brwf_pkg::MODE_RESAMPLE;
    w.coord_line   = cl;
    w.coord_sample = cs;
    return w;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Send one word and update the predictor when it is taken.
  task automatic send_word(input word_t w);
    bit taken;
    int a_l, a_s;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.mode;
    in_tdata  <= {6'd0, w.coord_sample, w.coord_line, w.pixel, w.load_sample, w.load_line};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    if (w.mode == brwf_pkg::MODE_RESAMPLE) begin
      expected_pixels.push_back(resample_expect(w));
    end else begin
      // 9-bit indices always fit the 512x512 store
      raster_model[pix_addr(w.load_line, w.load_sample)] = w.pixel;
      pix_written[pix_addr(w.load_line, w.load_sample)]  = 1'b1;
      // track 2x2 patches whose four pixels are now all loaded
      for (int dl = 0; dl < 2; dl++) begin
        for (int ds = 0; ds < 2; ds++) begin
          a_l = int'(w.load_line) - dl;
          a_s = int'(w.load_sample) - ds;
          if (a_l >= 0 && a_s >= 0 && a_l < LINES_MAX - 1 && a_s < SAMPLES_MAX - 1 &&
              !anchor_ready[pix_addr(a_l, a_s)] &&
              pix_written[pix_addr(a_l, a_s)] && pix_written[pix_addr(a_l, a_s + 1)] &&
              pix_written[pix_addr(a_l + 1, a_s)] &&
              pix_written[pix_addr(a_l + 1, a_s + 1)]) begin
            anchor_ready[pix_addr(a_l, a_s)] = 1'b1;
            anchors.push_back(pix_addr(a_l, a_s));
          end
        end
      end
    end
  endtask

  // Hold the sender until every result is back and the pipeline is empty.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [brwf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      brwf_pkg::CFG_FILL_VALUE:     fill_val_r = data;
      brwf_pkg::CFG_FILL_THRESHOLD: fill_thr_r = data;
      brwf_pkg::CFG_IMAGE_LINES:    lines_r    = data[9:0];
      brwf_pkg::CFG_IMAGE_SAMPLES:  samples_r  = data[9:0];
      default:                      ;
    endcase
  endtask

  // ---------------------------------------------------------------- result side
  // ready stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each taken result word with the oldest prediction
  always @(negedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: value %h fill %b",
                 $time, out_tdata, out_tuser[0]);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.value) begin
          mismatches++;
          $display("%0t: output_value expected %h actual %h", $time, want.value, out_tdata);
        end
        if (out_tuser[0] !== want.is_fill) begin
          mismatches++;
          $display("%0t: is_fill expected %b actual %b", $time, want.is_fill, out_tuser[0]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Reset settings: interpolation with extreme pixels, corners, outside points.
  task automatic test_basic_resample();
    send_word(load_word(0, 0, PIX_MAX));
    send_word(load_word(0, 1, 32'h0000_0000));
    send_word(load_word(1, 0, 32'h0001_0000));
    send_word(load_word(1, 1, 32'h7FFF_0000));
    send_word(load_word(510, 510, 32'd40));
    send_word(load_word(510, 511, 32'd30));
    send_word(load_word(511, 510, 32'd20));
    send_word(load_word(511, 511, 32'd10));
    send_word(resample_word(fix_q(0, 16'h8000), fix_q(0, 16'h8000)));
    send_word(resample_word(fix_q(0, 16'h0000), fix_q(0, 16'h0000)));
    send_word(resample_word(fix_q(0, 16'hFFFF), fix_q(0, 16'hFFFF)));
    send_word(resample_word(fix_q(510, 16'hFFFF), fix_q(510, 16'hFFFF)));
    // outside: last line, negative, largest coordinate
    send_word(resample_word(fix_q(511, 16'h0000), fix_q(0, 16'h0000)));
    send_word(resample_word(28'hFFF_FFFF, fix_q(0, 16'h0000)));
    send_word(resample_word(fix_q(0, 16'h0000), 28'h7FF_FFFF));
    wait_drain();
  endtask

  // Fill value extremes and a threshold that hits each neighbor in turn.
  task automatic test_fill_and_threshold();
    int levels [5] = '{41, 31, 21, 11, 10};
    write_cfg(brwf_pkg::CFG_FILL_VALUE, PIX_MIN);
    write_cfg(brwf_pkg::CFG_FILL_THRESHOLD, PIX_MAX);
    send_word(resample_word(28'h800_0000, fix_q(0, 16'h0000)));
    send_word(resample_word(fix_q(0, 16'h8000), fix_q(0, 16'h8000)));
    wait_drain();
    write_cfg(brwf_pkg::CFG_FILL_VALUE, PIX_MAX);
    send_word(resample_word(fix_q(0, 16'h0000), 28'h800_0000));
    foreach (levels[i]) begin
      wait_drain();
      write_cfg(brwf_pkg::CFG_FILL_THRESHOLD, levels[i]);
      send_word(resample_word(fix_q(510, 16'h4000), fix_q(510, 16'hC000)));
    end
    wait_drain();
    write_cfg(brwf_pkg::CFG_FILL_THRESHOLD, PIX_MIN);
    send_word(resample_word(fix_q(0, 16'h3000), fix_q(0, 16'hD000)));
    wait_drain();
  endtask

  // Smallest raster, sizes too small, sizes above the store, unknown register.
  task automatic test_raster_size();
    write_cfg(brwf_pkg::CFG_IMAGE_LINES, 32'hABCD_E402);
    write_cfg(brwf_pkg::CFG_IMAGE_SAMPLES, 32'h5555_5802);
    write_cfg(CFG_IDX_SPARE, 32'd0);
    send_word(resample_word(fix_q(0, 16'hCCCC), fix_q(0, 16'h4CCC)));
    send_word(resample_word(fix_q(1, 16'h0000), fix_q(0, 16'h0000)));
    send_word(resample_word(fix_q(0, 16'h0000), fix_q(1, 16'h0000)));
    wait_drain();
    write_cfg(brwf_pkg::CFG_IMAGE_LINES, 32'd0);
    send_word(resample_word(fix_q(0, 16'h0000), fix_q(0, 16'h0000)));
    wait_drain();
    write_cfg(brwf_pkg::CFG_IMAGE_LINES, 32'd1);
    send_word(resample_word(fix_q(0, 16'h8000), fix_q(0, 16'h8000)));
    wait_drain();
    // above the store: behaves as 512
    write_cfg(brwf_pkg::CFG_IMAGE_LINES, 32'h0000_03FF);
    write_cfg(brwf_pkg::CFG_IMAGE_SAMPLES, 32'h0000_03FF);
    send_word(resample_word(fix_q(510, 16'hFFFF), fix_q(510, 16'h0000)));
    send_word(resample_word(fix_q(0, 16'h0000), fix_q(511, 16'h0000)));
    wait_drain();
  endtask

  // Random settings per phase; mostly patch loads and resamples inside them.
  task automatic test_random_traffic();
    int                  sent, kind, pick, a_l, a_s;
    logic [31:0]         v;
    logic signed [brwf_pkg::COORD_W-1:0] cl, cs;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      quiet = (phase == RANDOM_PHASES - 1);
      case ($urandom_range(0, 3))
        0:       v = PIX_MIN;
        1:       v = PIX_MAX;
        default: v = $urandom;
      endcase
      write_cfg(brwf_pkg::CFG_FILL_VALUE, v);
      case ($urandom_range(0, 5))
        0:       v = PIX_MIN;
        1:       v = PIX_MAX;
        2:       v = 32'd0;
        default: v = $urandom | 32'h8000_0000;
      endcase
      write_cfg(brwf_pkg::CFG_FILL_THRESHOLD, v);
      write_cfg(brwf_pkg::CFG_IMAGE_LINES, pick_size());
      write_cfg(brwf_pkg::CFG_IMAGE_SAMPLES, pick_size());
      if ($urandom_range(0, 3) == 0) write_cfg(CFG_IDX_SPARE, $urandom);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 22 || anchors.size() == 0) begin
          // 2x2 patch, mostly near the origin
          if ($urandom_range(0, 3) != 0) begin
            a_l = $urandom_range(0, 15);
            a_s = $urandom_range(0, 15);
          end else begin
            a_l = $urandom_range(0, LINES_MAX - 2);
            a_s = $urandom_range(0, SAMPLES_MAX - 2);
          end
          for (int dl = 0; dl < 2; dl++)
            for (int ds = 0; ds < 2; ds++)
              send_word(load_word(a_l + dl, a_s + ds, rand_pixel()));
          sent += 4;
        end else if (kind < 27) begin
          send_word(load_word($urandom_range(0, LINES_MAX - 1),
                              $urandom_range(0, SAMPLES_MAX - 1), rand_pixel()));
          sent++;
        end else if (kind < 85) begin
          pick = anchors[$urandom_range(0, anchors.size() - 1)];
          cl   = fix_q(pick / SAMPLES_MAX, rand_frac());
          cs   = fix_q(pick % SAMPLES_MAX, rand_frac());
          send_word(resample_word(cl, cs));
          sent++;
        end else begin
          // noise: anywhere, or around the edge of the raster in use
          if ($urandom_range(0, 1) == 0) begin
            cl = CW'($urandom);
            cs = CW'($urandom);
          end else begin
            a_l = int'(lines_used()) - 2 + $urandom_range(0, 2);
            a_s = int'(samples_used()) - 2 + $urandom_range(0, 2);
            if (a_l < 0) a_l = 0;
            if (a_s < 0) a_s = 0;
            cl = fix_q(a_l, rand_frac());
            cs = fix_q(a_s, rand_frac());
          end
          if (reads_unwritten(cl, cs)) cl[brwf_pkg::COORD_W-1] = 1'b1;
          send_word(resample_word(cl, cs));
          sent++;
        end
        // occasionally hold off until every result is back
        if (!quiet && $urandom_range(0, 49) == 0) wait_drain();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_resample();
    test_fill_and_threshold();
    test_raster_size();
    test_random_traffic();
    wait_drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
